### sv/pss_pkg.sv
// pss_pkg: shared constants, codes and types of the slice display scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

  localparam int SLICES      = 128;
  localparam int SLICE_SHIFT = 7;
  localparam int TIMER_BITS  = 16;
  localparam int SLICE_W     = $clog2(SLICES);

  localparam int TYPE_W  = 2;
  localparam int ADDR_W  = 7;
  localparam int BITS_W  = 40;
  localparam int LINES   = 20;
  localparam int INDEX_W = 7;
  localparam int TIME_W  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // request type codes on the input channel
  localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SENSE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SENSE,
    OP_WRITE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SLICE_W-1:0]  addr;
    logic [BITS_W-1:0]   bits;
  } pss_cmd_t;

endpackage

`default_nettype wire

### sv/pss_if.sv
// pss_req_if / pss_res_if: valid-ready channels of the slice display scheduler
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pss_req_if;
  import pss_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [ADDR_W-1:0] slice_addr;
  logic [BITS_W-1:0] slice_bits;

  modport source (output valid, output req_type, output slice_addr, output slice_bits,
                  input ready);
  modport sink   (input valid, input req_type, input slice_addr, input slice_bits,
                  output ready);
endinterface

interface pss_res_if;
  import pss_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINES-1:0]   led_drive;
  logic               group_select;
  logic [INDEX_W-1:0] slice_index;
  logic [TIME_W-1:0]  slice_time;

  modport source (output valid, output led_drive, output group_select,
                  output slice_index, output slice_time, input ready);
  modport sink   (input valid, input led_drive, input group_select,
                  input slice_index, input slice_time, output ready);
endinterface

`default_nettype wire

### sv/pov_slice_display_scheduler_top.sv
// pov_slice_display_scheduler_top: rotating-display slice scheduler
// depends on pss_pkg, pss_if, pss_front, pss_queue, pss_back and pss_ram
//
// usage:
//   req_i carries one request per handshake: timer tick, rotation sensor
//   pulse, frame store write (slice_addr, slice_bits) or no operation.
//   res_o returns exactly one result per request, in order: the led lines
//   (active low), group select, current slice index and slice time.
//   throughput is one request per cycle while res_o.ready is high; the front
//   register, the command queue and the execute stage each take one request
//   every cycle. a result passes the front register, a queue slot, the frame
//   store read in the back and the output register on its way to res_o.
//   reset clears the counter and slice index, sets compares and slice time
//   to all ones, turns all leds off and marks every frame store slice as
//   dark; no clearing pass, requests are taken right after reset.
//   when the receiver holds res_o.ready low the result stays put, the back
//   stops, the queue fills and then req_i.ready drops; no request is lost.
`timescale 1ns / 1ps
`default_nettype none

module pov_slice_display_scheduler_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pss_req_if.sink    req_i,
  pss_res_if.source  res_o
);
  import pss_pkg::*;

  logic     f_valid, f_ready;
  pss_cmd_t f_cmd;
  logic     q_valid, q_ready;
  pss_cmd_t q_cmd;

  pss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  pss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_cmd_i   (f_cmd),
    .push_ready_o (f_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_ready_i  (q_ready)
  );

  pss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

### sv/pss_ram.sv
// pss_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/pss_front.sv
// pss_front: accepts requests and classifies them into commands
// depends on pss_pkg and pss_if
`timescale 1ns / 1ps
`default_nettype none

module pss_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  pss_req_if.sink                req_i,
  output logic                   cmd_valid_o,
  output pss_pkg::pss_cmd_t      cmd_o,
  input  wire logic              cmd_ready_i
);
  import pss_pkg::*;

  localparam logic [ADDR_W:0] SLICE_LIM = (ADDR_W + 1)'(SLICES);

  logic     valid_q, valid_d;
  pss_cmd_t cmd_q, cmd_d;
  logic     take;
  logic     wr_ok;

  assign req_i.ready = !valid_q || cmd_ready_i;
  assign take        = req_i.valid && req_i.ready;
  assign wr_ok       = {1'b0, req_i.slice_addr} < SLICE_LIM;

  always_comb begin
    cmd_d      = cmd_q;
    valid_d    = valid_q;
    if (take) begin
      valid_d   = 1'b1;
      cmd_d.addr = SLICE_W'(req_i.slice_addr);
      cmd_d.bits = req_i.slice_bits;
      case (req_i.req_type)
        REQ_TICK:  cmd_d.op = OP_TICK;
        REQ_SENSE: cmd_d.op = OP_SENSE;
        REQ_WRITE: cmd_d.op = wr_ok ? OP_WRITE : OP_NOP;
        default:   cmd_d.op = OP_NOP;
      endcase
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

### sv/pss_queue.sv
// pss_queue: short command queue between front and back
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pss_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  wire pss_pkg::pss_cmd_t push_cmd_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output pss_pkg::pss_cmd_t      pop_cmd_o,
  input  wire logic              pop_ready_i
);
  import pss_pkg::*;

  localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  pss_cmd_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != FULL_CNT;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### sv/pss_back.sv
// pss_back: executes commands: tick counter, compares, slice index, frame store
// depends on pss_pkg, pss_if and pss_ram
`timescale 1ns / 1ps
`default_nettype none

module pss_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire pss_pkg::pss_cmd_t cmd_i,
  output logic                   cmd_ready_o,
  pss_res_if.source              res_o
);
  import pss_pkg::*;

  localparam logic [SLICE_W-1:0] LAST_SLICE = SLICE_W'(SLICES - 1);

  // execute stage state
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic [TIMER_BITS-1:0] cmp_a_q, cmp_a_d;
  logic [TIMER_BITS-1:0] cmp_b_q, cmp_b_d;
  logic [TIMER_BITS-1:0] tps_q, tps_d;
  logic [SLICE_W-1:0]    cur_q, cur_d;
  logic [SLICES-1:0]     vld_q;

  // data stage
  logic                  mid_v_q;
  logic                  mid_show_q, mid_show_d;
  logic                  mid_odd_q, mid_odd_d;
  logic [SLICE_W-1:0]    mid_idx_q;
  logic [TIMER_BITS-1:0] mid_time_q;
  logic                  rd_vld_q;
  logic [BITS_W-1:0]     rd_data;

  // output register
  logic                  out_v_q;
  logic [LINES-1:0]      line_q, line_d;
  logic                  grp_q, grp_d;
  logic [SLICE_W-1:0]    out_idx_q;
  logic [TIMER_BITS-1:0] out_time_q;

  logic                  mid_mv, mid_free, s1_fire, wr_en;
  logic [TIMER_BITS-1:0] tick_n, tps_new;
  logic                  hit_a, hit_b;
  logic [BITS_W-1:0]     slice_bits;
  logic [LINES-1:0]      lit;

  assign mid_mv      = mid_v_q && (!out_v_q || res_o.ready);
  assign mid_free    = !mid_v_q || mid_mv;
  assign s1_fire     = cmd_valid_i && mid_free;
  assign cmd_ready_o = mid_free;
  assign wr_en       = s1_fire && (cmd_i.op == OP_WRITE);

  assign tick_n  = tick_q + 1'b1;
  assign tps_new = tick_q >> SLICE_SHIFT;
  assign hit_a   = tick_n == cmp_a_q;
  assign hit_b   = tick_n == cmp_b_q;

  always_comb begin
    tick_d     = tick_q;
    cmp_a_d    = cmp_a_q;
    cmp_b_d    = cmp_b_q;
    tps_d      = tps_q;
    cur_d      = cur_q;
    mid_show_d = 1'b0;
    mid_odd_d  = 1'b0;
    case (cmd_i.op)
      OP_TICK: begin
        tick_d = tick_n;
        if (hit_a) begin
          mid_show_d = 1'b1;
          cmp_a_d    = cmp_a_q + tps_q;
        end
        if (hit_b) begin
          mid_show_d = 1'b1;
          mid_odd_d  = 1'b1;
          cmp_b_d    = cmp_b_q + tps_q;
          if (cur_q != LAST_SLICE) begin
            cur_d = cur_q + 1'b1;
          end else begin
            cur_d   = '0;
            cmp_a_d = tps_q >> 1;
            cmp_b_d = tps_q;
          end
        end
      end
      OP_SENSE: begin
        tps_d   = tps_new;
        cmp_a_d = tps_new >> 1;
        cmp_b_d = tps_new;
        cur_d   = '0;
        tick_d  = '0;
      end
      default: begin
      end
    endcase
  end

  pss_ram #(
    .WIDTH (BITS_W),
    .DEPTH (SLICES)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.bits),
    .re_i    (s1_fire),
    .raddr_i (cur_q),
    .rdata_o (rd_data)
  );

  // never-written slices read as dark
  assign slice_bits = rd_vld_q ? rd_data : '0;

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      lit[i] = mid_odd_q ? slice_bits[2 * i + 1] : slice_bits[2 * i];
    end
    line_d = line_q;
    grp_d  = grp_q;
    if (mid_mv && mid_show_q) begin
      line_d = ~lit;
      grp_d  = !mid_odd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      cmp_a_q <= '1;
      cmp_b_q <= '1;
      tps_q   <= '1;
      cur_q   <= '0;
      vld_q   <= '0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
      line_q  <= '1;
      grp_q   <= 1'b1;
    end else begin
      if (s1_fire) begin
        tick_q  <= tick_d;
        cmp_a_q <= cmp_a_d;
        cmp_b_q <= cmp_b_d;
        tps_q   <= tps_d;
        cur_q   <= cur_d;
      end
      if (wr_en) begin
        vld_q[cmd_i.addr] <= 1'b1;
      end
      if (s1_fire) begin
        mid_v_q <= 1'b1;
      end else if (mid_mv) begin
        mid_v_q <= 1'b0;
      end
      if (mid_mv) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
      line_q <= line_d;
      grp_q  <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mid_show_q <= mid_show_d;
      mid_odd_q  <= mid_odd_d;
      mid_idx_q  <= cur_d;
      mid_time_q <= tps_d;
      rd_vld_q   <= vld_q[cur_q];
    end
    if (mid_mv) begin
      out_idx_q  <= mid_idx_q;
      out_time_q <= mid_time_q;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.led_drive    = line_q;
  assign res_o.group_select = grp_q;
  assign res_o.slice_index  = INDEX_W'(out_idx_q);
  assign res_o.slice_time   = TIME_W'(out_time_q);

`ifndef NO_ASSERTIONS
  a_sense_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && cmd_i.op == OP_SENSE |=> tick_q == '0 && cur_q == '0)
    else $error("sensor request did not clear counter and slice index");

  a_sense_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && cmd_i.op == OP_SENSE |=> cmp_b_q == tps_q && cmp_a_q == (tps_q >> 1))
    else $error("compares not reloaded from slice time");

  a_mid_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_mv |=> out_v_q)
    else $error("data stage moved without filling output register");

  a_stall_holds_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_o.ready |=> $stable(line_q) && $stable(grp_q))
    else $error("led lines changed while result stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_v_q && !mid_mv |-> !s1_fire)
    else $error("execute stage fired into occupied data stage");
`endif

endmodule

`default_nettype wire
